// ===== hw/rtl/mttm_pkg.sv =====
// ----------------------------------------------------------------------------
// mttm_pkg
// Shared sizes, codes and port structs for the multi-tape Turing machine.
// ----------------------------------------------------------------------------
package mttm_pkg;

    localparam int NUM_TAPES   = 4;
    localparam int TAPE_LEN    = 1024;
    localparam int NUM_RULES   = 64;
    localparam int NUM_STATES  = 64;
    localparam int FIELD_LANES = 4;
    localparam int LANES       = (NUM_TAPES < FIELD_LANES) ? NUM_TAPES : FIELD_LANES;

    localparam int TADDR_W = $clog2(TAPE_LEN);
    localparam int RIDX_W  = $clog2(NUM_RULES);
    localparam int KEY_W   = 38;
    localparam int ACT_W   = 46;

    // word kinds
    typedef enum logic [2:0] {
        K_LOAD  = 3'd0,
        K_CLEAR = 3'd1,
        K_WRITE = 3'd2,
        K_RUN   = 3'd3,
        K_READ  = 3'd4
    } kind_t;

    // result outcome codes
    typedef enum logic [2:0] {
        OC_DONE    = 3'd0,
        OC_FINAL   = 3'd1,
        OC_NOMATCH = 3'd2,
        OC_OFFTAPE = 3'd3,
        OC_LIMIT   = 3'd4
    } outcome_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TAPE_COUNT   = 3'd0,
        CFG_BLANK_SYMBOL = 3'd1,
        CFG_START_STATE  = 3'd2,
        CFG_FINAL_STATES = 3'd3,
        CFG_HEAD_START   = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RDISSUE,
        S_RDWAIT,
        S_CHECK,
        S_TREAD,
        S_RISSUE,
        S_RCMP,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic               we;
        logic [TADDR_W-1:0] waddr;
        logic [7:0]         wdata;
        logic [TADDR_W-1:0] raddr;
    } tape_port_t;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [KEY_W-1:0]  key;
        logic [ACT_W-1:0]  act;
    } rule_wr_t;

endpackage

// ===== hw/rtl/multi_tape_turing_machine.sv =====
// ----------------------------------------------------------------------------
// multi_tape_turing_machine
// Deterministic multi-tape Turing machine on bounded tapes, memory based.
// ----------------------------------------------------------------------------
// Usage: one input word (valid/ready) gives one result word (valid/ready).
// A word loads a rule, clears the tapes, writes or reads a cell, or runs
// the machine from start_state. Config is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while the block is idle, since the
// block itself does not enforce it. A clear sweeps the tape memories, one
// row a cycle. A run step does a final/limit test and a tape read, then
// scans the rule slots in order: an invalid slot is skipped on its flag
// alone, a valid one is also read through the rule memory's single
// registered read port and compared. One word is worked on at a time;
// in_ready is high whenever the engine is idle, even while a result still
// sits in the output register. If the receiver stalls, a finished word
// waits in the engine until the output register frees. Reset clears rule
// valid flags, heads, state and step count and sets config to its
// defaults; tape contents are undefined until a clear.
// ----------------------------------------------------------------------------
module multi_tape_turing_machine
    import mttm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [5:0]  rule_index,
    input  logic [5:0]  rule_state,
    input  logic [31:0] rule_read,
    input  logic [31:0] rule_write,
    input  logic [7:0]  rule_moves,
    input  logic [5:0]  rule_next,
    input  logic [1:0]  tape_select,
    input  logic [9:0]  cell_position,
    input  logic [7:0]  cell_symbol,
    input  logic [31:0] step_limit,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  outcome,
    output logic [31:0] step_count,
    output logic [5:0]  end_state,
    output logic [7:0]  cell_value,
    output logic [9:0]  head0_position
);

    // config registers
    logic [2:0]  tape_count_reg;
    logic [7:0]  blank_reg;
    logic [5:0]  start_reg;
    logic [63:0] final_reg;
    logic [9:0]  head_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tape_count_reg <= 3'd1;
            blank_reg      <= 8'd95;
            start_reg      <= '0;
            final_reg      <= '0;
            head_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAPE_COUNT:   tape_count_reg <= cfg_data[2:0];
                CFG_BLANK_SYMBOL: blank_reg      <= cfg_data[7:0];
                CFG_START_STATE:  start_reg      <= cfg_data[5:0];
                CFG_FINAL_STATES: final_reg      <= cfg_data;
                CFG_HEAD_START:   head_start_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // engine state
    fsm_t               fsm_reg, fsm_next;
    logic [1:0]         tsel_reg, tsel_next;
    logic [9:0]         pos_reg, pos_next;
    logic [31:0]        limit_reg, limit_next;
    logic [5:0]         cstate_reg, cstate_next;
    logic [31:0]        step_reg, step_next;
    logic [TADDR_W-1:0] head_reg [NUM_TAPES];
    logic [TADDR_W-1:0] head_next [NUM_TAPES];
    logic [7:0]         sym_reg [LANES];
    logic [7:0]         sym_next [LANES];
    logic [RIDX_W-1:0]  scan_reg, scan_next;
    logic [TADDR_W-1:0] clr_reg, clr_next;
    logic [2:0]         res_oc_reg, res_oc_next;
    logic [7:0]         res_val_reg, res_val_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_oc_reg, out_oc_next;
    logic [31:0] out_step_reg, out_step_next;
    logic [5:0]  out_state_reg, out_state_next;
    logic [7:0]  out_val_reg, out_val_next;
    logic [9:0]  out_head_reg, out_head_next;

    // memories
    tape_port_t         tport [NUM_TAPES];
    logic [7:0]         bank_rd [NUM_TAPES];
    rule_wr_t           rwr;
    logic [KEY_W-1:0]   r_key;
    logic [ACT_W-1:0]   r_act;
    logic               r_valid;

    logic               accept;
    logic               commit;
    logic [2:0]         lanes;
    logic [LANES-1:0]   lane_on;
    logic [7:0]         wsym [LANES];
    logic [TADDR_W-1:0] newpos [LANES];
    logic               off_tape;
    logic               sym_match;
    logic               is_final;
    logic [TADDR_W-1:0] hs;
    logic [7:0]         rd_mux;
    logic               rd_in_range;

    assign accept   = in_valid && in_ready;
    assign in_ready = (fsm_reg == S_IDLE);

    // active lanes: zero counts as one, capped at the lanes the rule holds
    always_comb
    begin
        logic [2:0] n;
        n     = (tape_count_reg == 3'd0) ? 3'd1 : tape_count_reg;
        lanes = (32'(n) > LANES) ? 3'(LANES) : n;
        for (int t = 0; t < LANES; t++)
        begin
            lane_on[t] = (t < 32'(lanes));
        end
    end

    assign hs = (32'(head_start_reg) >= TAPE_LEN) ? TADDR_W'(TAPE_LEN - 1)
                                                  : TADDR_W'(head_start_reg);

    assign is_final = (32'(cstate_reg) < NUM_STATES) && final_reg[cstate_reg];

    // per-lane decode of the rule being compared
    always_comb
    begin
        logic [1:0] mv;
        off_tape  = 1'b0;
        sym_match = 1'b1;
        for (int t = 0; t < LANES; t++)
        begin
            wsym[t]   = r_act[8*t +: 8];
            mv        = r_act[32 + 2*t +: 2];
            newpos[t] = head_reg[t];
            if (lane_on[t])
            begin
                if (sym_reg[t] != r_key[8*t +: 8])
                begin
                    sym_match = 1'b0;
                end
                if (mv == 2'd1)
                begin
                    if (head_reg[t] == '0)
                    begin
                        off_tape = 1'b1;
                    end
                    newpos[t] = head_reg[t] - 1'b1;
                end
                else if (mv == 2'd2)
                begin
                    if (head_reg[t] == TADDR_W'(TAPE_LEN - 1))
                    begin
                        off_tape = 1'b1;
                    end
                    newpos[t] = head_reg[t] + 1'b1;
                end
            end
        end
    end

    // read-cell mux
    always_comb
    begin
        rd_mux = '0;
        for (int t = 0; t < NUM_TAPES; t++)
        begin
            if (32'(tsel_reg) == t)
            begin
                rd_mux = bank_rd[t];
            end
        end
    end

    assign rd_in_range = (32'(tsel_reg) < NUM_TAPES) && (32'(pos_reg) < TAPE_LEN);

    // rule load straight from the accepted word
    always_comb
    begin
        rwr.en   = accept && (kind == K_LOAD) && (32'(rule_index) < NUM_RULES);
        rwr.addr = RIDX_W'(rule_index);
        rwr.key  = {rule_state, rule_read};
        rwr.act  = {rule_next, rule_moves, rule_write};
    end

    mttm_rule_mem u_rules (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (rwr),
        .rd_addr  (scan_reg),
        .rd_key   (r_key),
        .rd_act   (r_act),
        .rd_valid (r_valid)
    );

    // tape banks
    for (genvar g = 0; g < NUM_TAPES; g++)
    begin : g_tape
        always_comb
        begin
            tport[g].raddr = (fsm_reg == S_RDISSUE) ? TADDR_W'(pos_reg) : head_reg[g];
            tport[g].we    = 1'b0;
            tport[g].waddr = clr_reg;
            tport[g].wdata = blank_reg;
            if (fsm_reg == S_CLEAR)
            begin
                tport[g].we = 1'b1;
            end
            else if (accept && (kind == K_WRITE) && (32'(tape_select) == g)
                     && (32'(cell_position) < TAPE_LEN))
            begin
                tport[g].we    = 1'b1;
                tport[g].waddr = TADDR_W'(cell_position);
                tport[g].wdata = cell_symbol;
            end
            else if (commit)
            begin
                tport[g].waddr = head_reg[g];
                if (g < LANES)
                begin
                    tport[g].we    = lane_on[g];
                    tport[g].wdata = wsym[g];
                end
            end
        end

        mttm_tape_bank u_bank (
            .clk     (clk),
            .port    (tport[g]),
            .rd_data (bank_rd[g])
        );
    end

    // engine next state
    always_comb
    begin
        fsm_next     = fsm_reg;
        tsel_next    = tsel_reg;
        pos_next     = pos_reg;
        limit_next   = limit_reg;
        cstate_next  = cstate_reg;
        step_next    = step_reg;
        head_next    = head_reg;
        sym_next     = sym_reg;
        scan_next    = scan_reg;
        clr_next     = clr_reg;
        res_oc_next  = res_oc_reg;
        res_val_next = res_val_reg;
        commit       = 1'b0;

        out_valid_next = out_valid_reg;
        out_oc_next    = out_oc_reg;
        out_step_next  = out_step_reg;
        out_state_next = out_state_reg;
        out_val_next   = out_val_reg;
        out_head_next  = out_head_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tsel_next    = tape_select;
                    pos_next     = cell_position;
                    limit_next   = step_limit;
                    res_oc_next  = OC_DONE;
                    res_val_next = '0;
                    case (kind)
                        K_CLEAR:
                        begin
                            clr_next = '0;
                            fsm_next = S_CLEAR;
                        end
                        K_RUN:
                        begin
                            cstate_next = start_reg;
                            step_next   = '0;
                            fsm_next    = S_CHECK;
                        end
                        K_READ:  fsm_next = S_RDISSUE;
                        default: fsm_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (clr_reg == TADDR_W'(TAPE_LEN - 1))
                begin
                    for (int t = 0; t < NUM_TAPES; t++)
                    begin
                        head_next[t] = hs;
                    end
                    fsm_next = S_DONE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_RDISSUE: fsm_next = S_RDWAIT;
            S_RDWAIT:
            begin
                res_val_next = rd_in_range ? rd_mux : 8'd0;
                fsm_next     = S_DONE;
            end
            S_CHECK:
            begin
                if (is_final)
                begin
                    res_oc_next = OC_FINAL;
                    fsm_next    = S_DONE;
                end
                else if (step_reg >= limit_reg)
                begin
                    res_oc_next = OC_LIMIT;
                    fsm_next    = S_DONE;
                end
                else
                begin
                    fsm_next = S_TREAD;
                end
            end
            S_TREAD:
            begin
                for (int t = 0; t < LANES; t++)
                begin
                    sym_next[t] = bank_rd[t];
                end
                scan_next = '0;
                fsm_next  = S_RISSUE;
            end
            S_RISSUE:
            begin
                if (r_valid)
                begin
                    fsm_next = S_RCMP;
                end
                else if (scan_reg == RIDX_W'(NUM_RULES - 1))
                begin
                    res_oc_next = OC_NOMATCH;
                    fsm_next    = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_RCMP:
            begin
                if ((r_key[37:32] == cstate_reg) && sym_match)
                begin
                    if (off_tape)
                    begin
                        res_oc_next = OC_OFFTAPE;
                        fsm_next    = S_DONE;
                    end
                    else
                    begin
                        commit = 1'b1;
                        for (int t = 0; t < LANES; t++)
                        begin
                            head_next[t] = newpos[t];
                        end
                        cstate_next = r_act[45:40];
                        step_next   = step_reg + 32'd1;
                        fsm_next    = S_CHECK;
                    end
                end
                else if (scan_reg == RIDX_W'(NUM_RULES - 1))
                begin
                    res_oc_next = OC_NOMATCH;
                    fsm_next    = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    fsm_next  = S_RISSUE;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_oc_next    = res_oc_reg;
                    out_step_next  = step_reg;
                    out_state_next = cstate_reg;
                    out_val_next   = res_val_reg;
                    out_head_next  = 10'(head_reg[0]);
                    fsm_next       = S_IDLE;
                end
            end
            default: fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            cstate_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NUM_TAPES; t++)
            begin
                head_reg[t] <= '0;
            end
        end
        else
        begin
            fsm_reg       <= fsm_next;
            cstate_reg    <= cstate_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tsel_reg      <= tsel_next;
        pos_reg       <= pos_next;
        limit_reg     <= limit_next;
        sym_reg       <= sym_next;
        scan_reg      <= scan_next;
        clr_reg       <= clr_next;
        res_oc_reg    <= res_oc_next;
        res_val_reg   <= res_val_next;
        out_oc_reg    <= out_oc_next;
        out_step_reg  <= out_step_next;
        out_state_reg <= out_state_next;
        out_val_reg   <= out_val_next;
        out_head_reg  <= out_head_next;
    end

    assign out_valid      = out_valid_reg;
    assign outcome        = out_oc_reg;
    assign step_count     = out_step_reg;
    assign end_state      = out_state_reg;
    assign cell_value     = out_val_reg;
    assign head0_position = out_head_reg;

    // step count moves by at most one while the engine is busy
    a_step_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg != S_IDLE) |=> (step_reg == $past(step_reg))
                             || (step_reg == $past(step_reg) + 32'd1))
        else $error("step counter jumped");

    // head 0 never leaves the tape
    a_head_in: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg[0]) < TAPE_LEN)
        else $error("head 0 off tape");

    // every accepted word starts work
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (fsm_reg != S_IDLE))
        else $error("accepted word dropped");

    // a step is only committed on a valid, matching rule
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (fsm_reg == S_RCMP) && !off_tape && sym_match)
        else $error("bad commit");

endmodule

// ===== hw/rtl/mttm_tape_bank.sv =====
// ----------------------------------------------------------------------------
// mttm_tape_bank
// One tape: single write port, single registered read port.
// ----------------------------------------------------------------------------
module mttm_tape_bank
    import mttm_pkg::*;
(
    input  logic       clk,
    input  tape_port_t port,
    output logic [7:0] rd_data
);

    logic [7:0] mem [TAPE_LEN];

    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
        rd_data <= mem[port.raddr];
    end

endmodule

// ===== hw/rtl/mttm_rule_mem.sv =====
// ----------------------------------------------------------------------------
// mttm_rule_mem
// Rule table: key and action store plus per-slot valid flags.
// ----------------------------------------------------------------------------
module mttm_rule_mem
    import mttm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rule_wr_t          wr,
    input  logic [RIDX_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_key,
    output logic [ACT_W-1:0]  rd_act,
    output logic              rd_valid
);

    logic [KEY_W+ACT_W-1:0] mem [NUM_RULES];
    logic [NUM_RULES-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.key, wr.act};
        end
        {rd_key, rd_act} <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // flag of the slot being addressed, not delayed
    assign rd_valid = valid_reg[rd_addr];

endmodule
